FILE: design/gnb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes of the n-body step unit.
package gnb_pkg;

  localparam int FRAC_BITS      = 32;
  localparam int MAX_BODIES_DEF = 32;
  localparam int POS_W          = 48;
  localparam int MASS_W         = 16;
  localparam int RAD_W          = 12;
  localparam int GM_W           = 32;
  localparam int FUNC_W         = 2;
  localparam int INDEX_W        = 5;
  localparam int T_FRAC         = 32;
  localparam int T_W            = 64;

  localparam int DIFF_W  = POS_W + 1;
  localparam int D2_W    = 2 * DIFF_W;
  localparam int REM_W   = D2_W + 1;
  localparam int ROOT_W  = DIFF_W;
  localparam int UX_W    = FRAC_BITS + 1;
  localparam int GMM_W   = GM_W + MASS_W;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int DIGIT_W = 16;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 64;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ITER_W  = $clog2(2 * FRAC_BITS + 2);

  localparam logic [ITER_W-1:0] STEPS_MUL  = ITER_W'(MUL_B_W / DIGIT_W);
  localparam logic [ITER_W-1:0] STEPS_SQRT = ITER_W'(D2_W / 2);
  localparam logic [ITER_W-1:0] STEPS_TDIV = ITER_W'(2 * FRAC_BITS + 1);
  localparam logic [ITER_W-1:0] STEPS_UDIV = ITER_W'(FRAC_BITS + 1);

  localparam logic [GM_W-1:0]  GM_RESET = GM_W'(286474319);
  localparam logic [POS_W-1:0] TERM_CAP = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [ITER_W-1:0] steps;
  } alu_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  vel_x;
    logic [POS_W-1:0]  vel_y;
    logic [MASS_W-1:0] mass;
    logic [RAD_W-1:0]  radius;
  } body_rec_t;

endpackage

FILE: design/gnb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/gnb_alu.sv
`timescale 1ns / 1ps
// Shared iterative unit: digit-serial multiply, restoring divide, digit square root.
module gnb_alu import gnb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  alu_ctl_t          ctl,
  input  logic [D2_W-1:0]   opa,
  input  logic [D2_W-1:0]   opb,
  output logic              busy,
  output logic [PROD_W-1:0] result
);

  alu_op_t                     mode;
  logic                        first;
  logic [ITER_W-1:0]           cnt;
  logic [REM_W-1:0]            rem;
  logic [D2_W-1:0]             den;
  logic [D2_W-1:0]             sh;
  logic [PROD_W-1:0]           acc;
  logic [REM_W-1:0]            cand;
  logic [REM_W-1:0]            subtr;
  logic [REM_W:0]              diff;
  logic                        ge;
  logic [MUL_A_W+DIGIT_W-1:0]  pp;

  always_comb begin
    if (mode == OP_SQRT) begin
      cand  = {rem[REM_W-3:0], sh[D2_W-1 -: 2]};
      subtr = {acc[REM_W-3:0], 2'b01};
    end else begin
      cand  = first ? rem : {rem[REM_W-2:0], 1'b0};
      subtr = {1'b0, den};
    end
    diff = {1'b0, cand} - {1'b0, subtr};
    ge   = !diff[REM_W];
    pp   = den[MUL_A_W-1:0] * sh[MUL_B_W-1 -: DIGIT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      mode  <= ctl.op;
      cnt   <= ctl.steps;
      first <= 1'b1;
      acc   <= '0;
      rem   <= (ctl.op == OP_DIV) ? {1'b0, opa} : '0;
      den   <= (ctl.op == OP_MUL) ? opa : opb;
      sh    <= (ctl.op == OP_SQRT) ? opa : opb;
    end else if (busy) begin
      first <= 1'b0;
      cnt   <= cnt - 1'b1;
      if (cnt == ITER_W'(1)) begin
        busy <= 1'b0;
      end
      unique case (mode)
        OP_MUL: begin
          acc <= (acc << DIGIT_W) + PROD_W'(pp);
          sh  <= sh << DIGIT_W;
        end
        OP_DIV: begin
          rem <= ge ? diff[REM_W-1:0] : cand;
          acc <= {acc[PROD_W-2:0], ge};
        end
        OP_SQRT: begin
          rem <= ge ? diff[REM_W-1:0] : cand;
          acc <= {acc[PROD_W-2:0], ge};
          sh  <= sh << 2;
        end
        default: ;
      endcase
    end
  end

  assign result = acc;

endmodule

FILE: design/gravity_nbody_step_unit.sv
`timescale 1ns / 1ps
// Top level: body store, pair sequencer and result register of the n-body step unit.
//
// Input channel (in_valid/in_ready) takes one word per command: func 0 appends a
// body (ignored once MAX_BODIES are stored), 1 empties the store, 2 runs one step.
// Add and clear give no result. A step emits one result word per
// stored body on out_valid/out_ready, in stored order, last set on the final one.
// Config channel (cfg_valid/cfg_ready) writes gm_per_unit; it is always ready.
// A step is sequenced over one shared multiply/divide/sqrt unit: each ordered pair
// runs two squaring multiplies, a square root, one divide for the force term and,
// per axis, a divide and a multiply; a pair closer than the larger radius is skipped
// after the squares. in_ready is low for the whole step.
// Results sit in an output register; a stalled receiver holds the next body's
// write-back until the register frees, and the sequencer waits there.
// Reset (rst, synchronous) empties the store, drops any pending result and
// restores gm_per_unit to its reset value; store contents are not cleared.
module gravity_nbody_step_unit import gnb_pkg::*; #(
  parameter int MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [GM_W-1:0]          gm_per_unit,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [POS_W-1:0]  init_pos_x,
  input  logic signed [POS_W-1:0]  init_pos_y,
  input  logic signed [POS_W-1:0]  init_vel_x,
  input  logic signed [POS_W-1:0]  init_vel_y,
  input  logic [MASS_W-1:0]        body_mass,
  input  logic [RAD_W-1:0]         body_radius,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [INDEX_W-1:0]       body_index,
  output logic signed [POS_W-1:0]  new_pos_x,
  output logic signed [POS_W-1:0]  new_pos_y,
  output logic signed [POS_W-1:0]  new_vel_x,
  output logic signed [POS_W-1:0]  new_vel_y,
  output logic signed [POS_W-1:0]  accel_x,
  output logic signed [POS_W-1:0]  accel_y,
  output logic                     last
);

  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_LD_I, S_PAIR_RD, S_PAIR_LD,
    S_SQX_GO, S_SQX_W, S_SQY_GO, S_SQY_W, S_CHK,
    S_SQRT_GO, S_SQRT_W, S_TDIV_GO, S_TDIV_W,
    S_UDIV_GO, S_UDIV_W, S_TMUL_GO, S_TMUL_W, S_ACC,
    S_UPD_V, S_UPD_P
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    i;
  logic [CNT_W-1:0]    j;
  logic [GM_W-1:0]     gm;
  body_rec_t           rec_i;
  logic [MASS_W-1:0]   mass_j;
  logic [RAD_W-1:0]    rad_max;
  logic [DIFF_W-1:0]   dx;
  logic [DIFF_W-1:0]   dy;
  logic [DIFF_W-1:0]   mx;
  logic [DIFF_W-1:0]   my;
  logic [D2_W-1:0]     sqx;
  logic [D2_W-1:0]     d2;
  logic [ROOT_W-1:0]   d;
  logic [T_W-1:0]      t;
  logic [UX_W-1:0]     ux;
  logic                axis;
  logic [POS_W-1:0]    ax;
  logic [POS_W-1:0]    ay;

  alu_ctl_t            alu_ctl;
  logic [D2_W-1:0]     alu_a;
  logic [D2_W-1:0]     alu_b;
  logic                alu_busy;
  logic [PROD_W-1:0]   alu_result;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  body_rec_t           ram_wdata;
  body_rec_t           ram_rdata;

  logic [DIFF_W-1:0]   abs_dx;
  logic [DIFF_W-1:0]   abs_dy;
  logic [RSQ_W-1:0]    rsq;
  logic                skip;
  logic                out_free;
  logic                add_ok;
  logic [POS_W-1:0]    pos_x_new;
  logic [POS_W-1:0]    pos_y_new;
  logic [POS_W-1:0]    pmid;
  logic                cap;
  logic [POS_W-1:0]    mag_term;
  logic                neg;
  logic [POS_W-1:0]    acc_cur;
  logic [POS_W+1:0]    term;
  logic [POS_W+1:0]    sum;
  logic [POS_W-1:0]    sum_sat;

  gnb_ram #(
    .WIDTH ($bits(body_rec_t)),
    .DEPTH (MAX_BODIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gnb_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .opa    (alu_a),
    .opb    (alu_b),
    .busy   (alu_busy),
    .result (alu_result)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign add_ok    = (count < CNT_W'(MAX_BODIES));

  assign abs_dx    = dx[DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign abs_dy    = dy[DIFF_W-1] ? (~dy + 1'b1) : dy;
  assign rsq       = rad_max * rad_max;
  assign skip      = (d2 == '0) ||
                     ({{(D2_W - RSQ_W){1'b0}}, rsq} << (2 * FRAC_BITS)) > d2;
  assign pos_x_new = rec_i.pos_x + rec_i.vel_x;
  assign pos_y_new = rec_i.pos_y + rec_i.vel_y;

  // pair term: (t * u) >> 32, capped, signed, added with saturation
  assign pmid     = alu_result[T_FRAC+POS_W-1:T_FRAC];
  assign cap      = (alu_result[PROD_W-1:T_FRAC+POS_W] != '0) || (pmid > TERM_CAP);
  assign mag_term = cap ? TERM_CAP : pmid;
  assign neg      = axis ? dy[DIFF_W-1] : dx[DIFF_W-1];
  assign acc_cur  = axis ? ay : ax;
  assign term     = neg ? (~{2'b00, mag_term} + 1'b1) : {2'b00, mag_term};
  assign sum      = {{2{acc_cur[POS_W-1]}}, acc_cur} + term;

  always_comb begin
    if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
      sum_sat = sum[POS_W-1:0];
    end else if (sum[POS_W+1]) begin
      sum_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    alu_ctl = '{start: 1'b0, op: OP_MUL, steps: STEPS_MUL};
    alu_a   = '0;
    alu_b   = '0;
    unique case (state)
      S_SQX_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_MUL, steps: STEPS_MUL};
        alu_a   = D2_W'(abs_dx);
        alu_b   = D2_W'(abs_dx);
      end
      S_SQY_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_MUL, steps: STEPS_MUL};
        alu_a   = D2_W'(my);
        alu_b   = D2_W'(my);
      end
      S_SQRT_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_SQRT, steps: STEPS_SQRT};
        alu_a   = d2;
      end
      S_TDIV_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_DIV, steps: STEPS_TDIV};
        alu_a   = D2_W'(GMM_W'(gm) * GMM_W'(mass_j));
        alu_b   = d2;
      end
      S_UDIV_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_DIV, steps: STEPS_UDIV};
        alu_a   = D2_W'(axis ? my : mx);
        alu_b   = D2_W'(d);
      end
      S_TMUL_GO: begin
        alu_ctl = '{start: 1'b1, op: OP_MUL, steps: STEPS_MUL};
        alu_a   = D2_W'(t);
        alu_b   = D2_W'(ux);
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_raddr = (state == S_RD_I) ? i[IDX_W-1:0] : j[IDX_W-1:0];
    if (state == S_UPD_P) begin
      ram_we    = out_free;
      ram_waddr = i[IDX_W-1:0];
      ram_wdata = '{pos_x: pos_x_new, pos_y: pos_y_new, vel_x: rec_i.vel_x,
                    vel_y: rec_i.vel_y, mass: rec_i.mass, radius: rec_i.radius};
    end else begin
      ram_we    = (state == S_IDLE) && in_valid && (func == FUNC_ADD) && add_ok;
      ram_waddr = count[IDX_W-1:0];
      ram_wdata = '{pos_x: init_pos_x, pos_y: init_pos_y, vel_x: init_vel_x,
                    vel_y: init_vel_y, mass: body_mass, radius: body_radius};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      gm        <= GM_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gm <= gm_per_unit;
      end
      if (out_valid && out_ready && state != S_UPD_P) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (func)
              FUNC_ADD: begin
                if (add_ok) begin
                  count <= count + 1'b1;
                end
              end
              FUNC_CLEAR: count <= '0;
              FUNC_STEP: begin
                i <= '0;
                if (count != '0) begin
                  state <= S_RD_I;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_I: state <= S_LD_I;
        S_LD_I: begin
          rec_i <= ram_rdata;
          ax    <= '0;
          ay    <= '0;
          j     <= '0;
          state <= S_PAIR_RD;
        end
        S_PAIR_RD: begin
          if (j == count) begin
            state <= S_UPD_V;
          end else if (j == i) begin
            j <= j + 1'b1;
          end else begin
            state <= S_PAIR_LD;
          end
        end
        S_PAIR_LD: begin
          dx      <= {ram_rdata.pos_x[POS_W-1], ram_rdata.pos_x} -
                     {rec_i.pos_x[POS_W-1], rec_i.pos_x};
          dy      <= {ram_rdata.pos_y[POS_W-1], ram_rdata.pos_y} -
                     {rec_i.pos_y[POS_W-1], rec_i.pos_y};
          mass_j  <= ram_rdata.mass;
          rad_max <= (ram_rdata.radius > rec_i.radius) ? ram_rdata.radius : rec_i.radius;
          axis    <= 1'b0;
          state   <= S_SQX_GO;
        end
        S_SQX_GO: begin
          mx    <= abs_dx;
          my    <= abs_dy;
          state <= S_SQX_W;
        end
        S_SQX_W: begin
          if (!alu_busy) begin
            sqx   <= alu_result[D2_W-1:0];
            state <= S_SQY_GO;
          end
        end
        S_SQY_GO: state <= S_SQY_W;
        S_SQY_W: begin
          if (!alu_busy) begin
            d2    <= sqx + alu_result[D2_W-1:0];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (skip) begin
            j     <= j + 1'b1;
            state <= S_PAIR_RD;
          end else begin
            state <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (!alu_busy) begin
            d     <= alu_result[ROOT_W-1:0];
            state <= S_TDIV_GO;
          end
        end
        S_TDIV_GO: state <= S_TDIV_W;
        S_TDIV_W: begin
          if (!alu_busy) begin
            t     <= alu_result[2*FRAC_BITS] ? '1 : alu_result[T_W-1:0];
            state <= S_UDIV_GO;
          end
        end
        S_UDIV_GO: state <= S_UDIV_W;
        S_UDIV_W: begin
          if (!alu_busy) begin
            ux    <= alu_result[UX_W-1:0];
            state <= S_TMUL_GO;
          end
        end
        S_TMUL_GO: state <= S_TMUL_W;
        S_TMUL_W: begin
          if (!alu_busy) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (!axis) begin
            ax    <= sum_sat;
            axis  <= 1'b1;
            state <= S_UDIV_GO;
          end else begin
            ay    <= sum_sat;
            j     <= j + 1'b1;
            state <= S_PAIR_RD;
          end
        end
        S_UPD_V: begin
          rec_i.vel_x <= rec_i.vel_x + ax;
          rec_i.vel_y <= rec_i.vel_y + ay;
          state       <= S_UPD_P;
        end
        S_UPD_P: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            body_index <= INDEX_W'(i);
            new_pos_x  <= pos_x_new;
            new_pos_y  <= pos_y_new;
            new_vel_x  <= rec_i.vel_x;
            new_vel_y  <= rec_i.vel_y;
            accel_x    <= ax;
            accel_y    <= ay;
            last       <= (i + 1'b1 == count);
            i          <= i + 1'b1;
            state      <= (i + 1'b1 == count) ? S_IDLE : S_RD_I;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gnb_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the n-body step unit, bound to the top level.
module gnb_checker import gnb_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [INDEX_W-1:0]      body_index,
  input logic signed [POS_W-1:0] new_pos_x,
  input logic                    last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(body_index))
    else $error("result word changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || body_index == '0)
    else $error("step does not start at body zero");

  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      !out_valid || body_index == INDEX_W'($past(body_index) + 1'b1))
    else $error("body index skipped");

endmodule

bind gravity_nbody_step_unit gnb_checker u_gnb_checker (.*);
